FILE: rtl/core/qpr_pkg.sv
// Shared constants, register indexes and types of the quaternion point rotator.
package qpr_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int QUAT_WIDTH  = 18;
    localparam int QUAT_FRAC   = 16;

    // Offset point, products, sums and rounded results of both passes.
    localparam int D_W  = COORD_WIDTH + 1;
    localparam int P1_W = D_W + QUAT_WIDTH;
    localparam int S1_W = P1_W + 2;
    localparam int T_W  = S1_W - QUAT_FRAC;
    localparam int P2_W = T_W + QUAT_WIDTH;
    localparam int S2_W = P2_W + 2;
    localparam int R_W  = S2_W - QUAT_FRAC;

    localparam int TDATA_W    = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_W   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_X   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_Y   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_QUAT_Z   = 3'd6;

    localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << QUAT_FRAC;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] w;
        logic signed [QUAT_WIDTH-1:0] x;
        logic signed [QUAT_WIDTH-1:0] y;
        logic signed [QUAT_WIDTH-1:0] z;
    } quat_t;

endpackage

FILE: rtl/core/qpr_offset.sv
// First pipeline stage: subtracts the rotation origin from the incoming point.
module qpr_offset (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [qpr_pkg::COORD_WIDTH-1:0] pos_x,
    input  logic signed [qpr_pkg::COORD_WIDTH-1:0] pos_y,
    input  logic signed [qpr_pkg::COORD_WIDTH-1:0] pos_z,
    input  logic                                  in_last,
    input  logic signed [qpr_pkg::COORD_WIDTH-1:0] origin_x,
    input  logic signed [qpr_pkg::COORD_WIDTH-1:0] origin_y,
    input  logic signed [qpr_pkg::COORD_WIDTH-1:0] origin_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [qpr_pkg::D_W-1:0]         dx,
    output logic signed [qpr_pkg::D_W-1:0]         dy,
    output logic signed [qpr_pkg::D_W-1:0]         dz,
    output logic                                  out_last
);
    import qpr_pkg::*;

    logic                  valid_reg;
    logic signed [D_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [D_W-1:0] dx_next, dy_next, dz_next;
    logic                  last_reg;
    logic                  en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    assign dx_next = D_W'(pos_x) - D_W'(origin_x);
    assign dy_next = D_W'(pos_y) - D_W'(origin_y);
    assign dz_next = D_W'(pos_z) - D_W'(origin_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            dz_reg   <= dz_next;
            last_reg <= in_last;
        end
    end

    assign out_valid = valid_reg;
    assign dx        = dx_reg;
    assign dy        = dy_reg;
    assign dz        = dz_reg;
    assign out_last  = last_reg;

endmodule

FILE: rtl/core/qpr_left_mul.sv
// Two pipeline stages forming t = q * (0, d): twelve registered products, then rounded sums.
module qpr_left_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [qpr_pkg::D_W-1:0] dx,
    input  logic signed [qpr_pkg::D_W-1:0] dy,
    input  logic signed [qpr_pkg::D_W-1:0] dz,
    input  logic                           in_last,
    input  qpr_pkg::quat_t                 quat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [qpr_pkg::T_W-1:0] ts,
    output logic signed [qpr_pkg::T_W-1:0] ti,
    output logic signed [qpr_pkg::T_W-1:0] tj,
    output logic signed [qpr_pkg::T_W-1:0] tk,
    output logic                           out_last
);
    import qpr_pkg::*;

    localparam logic signed [S1_W-1:0] HALF = S1_W'(1) << (QUAT_FRAC - 1);

    logic                   prod_valid_reg;
    logic signed [P1_W-1:0] prod_reg  [12];
    logic signed [P1_W-1:0] prod_next [12];
    logic                   prod_last_reg;

    logic                   t_valid_reg;
    logic signed [T_W-1:0]  ts_reg, ti_reg, tj_reg, tk_reg;
    logic                   t_last_reg;

    logic signed [S1_W-1:0] sum_s, sum_i, sum_j, sum_k;
    logic                   en_prod, en_t;

    assign en_t     = !t_valid_reg || out_ready;
    assign en_prod  = !prod_valid_reg || en_t;
    assign in_ready = en_prod;

    // Product order: ax by cz wx bz cy wy cx az wz ay bx.
    assign prod_next[0]  = quat.x * dx;
    assign prod_next[1]  = quat.y * dy;
    assign prod_next[2]  = quat.z * dz;
    assign prod_next[3]  = quat.w * dx;
    assign prod_next[4]  = quat.y * dz;
    assign prod_next[5]  = quat.z * dy;
    assign prod_next[6]  = quat.w * dy;
    assign prod_next[7]  = quat.z * dx;
    assign prod_next[8]  = quat.x * dz;
    assign prod_next[9]  = quat.w * dz;
    assign prod_next[10] = quat.x * dy;
    assign prod_next[11] = quat.y * dx;

    // Sums with the rounding half added; dropping the fraction bits then
    // rounds to nearest with ties toward plus infinity.
    assign sum_s = HALF - S1_W'(prod_reg[0]) - S1_W'(prod_reg[1]) - S1_W'(prod_reg[2]);
    assign sum_i = HALF + S1_W'(prod_reg[3]) + S1_W'(prod_reg[4]) - S1_W'(prod_reg[5]);
    assign sum_j = HALF + S1_W'(prod_reg[6]) + S1_W'(prod_reg[7]) - S1_W'(prod_reg[8]);
    assign sum_k = HALF + S1_W'(prod_reg[9]) + S1_W'(prod_reg[10]) - S1_W'(prod_reg[11]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            t_valid_reg    <= 1'b0;
        end
        else
        begin
            if (en_prod)
            begin
                prod_valid_reg <= in_valid;
            end
            if (en_t)
            begin
                t_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_prod && in_valid)
        begin
            prod_reg      <= prod_next;
            prod_last_reg <= in_last;
        end
        if (en_t && prod_valid_reg)
        begin
            ts_reg     <= sum_s[S1_W-1:QUAT_FRAC];
            ti_reg     <= sum_i[S1_W-1:QUAT_FRAC];
            tj_reg     <= sum_j[S1_W-1:QUAT_FRAC];
            tk_reg     <= sum_k[S1_W-1:QUAT_FRAC];
            t_last_reg <= prod_last_reg;
        end
    end

    assign out_valid = t_valid_reg;
    assign ts        = ts_reg;
    assign ti        = ti_reg;
    assign tj        = tj_reg;
    assign tk        = tk_reg;
    assign out_last  = t_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (prod_valid_reg && t_valid_reg && !out_ready))
        else $error("left multiplier stalled without a full pipeline");

endmodule

FILE: rtl/core/qpr_right_mul.sv
// Two pipeline stages forming the vector part of t * conj(q), rounded and saturated.
module qpr_right_mul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [qpr_pkg::T_W-1:0]         ts,
    input  logic signed [qpr_pkg::T_W-1:0]         ti,
    input  logic signed [qpr_pkg::T_W-1:0]         tj,
    input  logic signed [qpr_pkg::T_W-1:0]         tk,
    input  logic                                   in_last,
    input  qpr_pkg::quat_t                         quat,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [qpr_pkg::COORD_WIDTH-1:0] rot_x,
    output logic signed [qpr_pkg::COORD_WIDTH-1:0] rot_y,
    output logic signed [qpr_pkg::COORD_WIDTH-1:0] rot_z,
    output logic                                   saturated,
    output logic                                   out_last
);
    import qpr_pkg::*;

    localparam logic signed [S2_W-1:0] HALF = S2_W'(1) << (QUAT_FRAC - 1);

    logic                   prod_valid_reg;
    logic signed [P2_W-1:0] prod_reg  [12];
    logic signed [P2_W-1:0] prod_next [12];
    logic                   prod_last_reg;

    logic                          res_valid_reg;
    logic signed [COORD_WIDTH-1:0] rx_reg, ry_reg, rz_reg;
    logic                          sat_reg;
    logic                          res_last_reg;

    logic signed [S2_W-1:0]  sum_x, sum_y, sum_z;
    logic [COORD_WIDTH:0]    cx, cy, cz;
    logic                    en_prod, en_res;

    // Clips a rounded value to the coordinate range; the top bit flags clipping.
    function automatic logic [COORD_WIDTH:0] clip(input logic signed [R_W-1:0] r);
        logic [R_W-COORD_WIDTH:0] top;
        logic [COORD_WIDTH:0]     res;
        top = r[R_W-1:COORD_WIDTH-1];
        if ((&top) || !(|top))
        begin
            res = {1'b0, r[COORD_WIDTH-1:0]};
        end
        else if (r[R_W-1])
        begin
            res = {1'b1, COORD_MIN};
        end
        else
        begin
            res = {1'b1, COORD_MAX};
        end
        return res;
    endfunction

    assign en_res   = !res_valid_reg || out_ready;
    assign en_prod  = !prod_valid_reg || en_res;
    assign in_ready = en_prod;

    // Product order: a*ts w*ti c*tj b*tk  b*ts w*tj a*tk c*ti  c*ts w*tk b*ti a*tj.
    assign prod_next[0]  = quat.x * ts;
    assign prod_next[1]  = quat.w * ti;
    assign prod_next[2]  = quat.z * tj;
    assign prod_next[3]  = quat.y * tk;
    assign prod_next[4]  = quat.y * ts;
    assign prod_next[5]  = quat.w * tj;
    assign prod_next[6]  = quat.x * tk;
    assign prod_next[7]  = quat.z * ti;
    assign prod_next[8]  = quat.z * ts;
    assign prod_next[9]  = quat.w * tk;
    assign prod_next[10] = quat.y * ti;
    assign prod_next[11] = quat.x * tj;

    assign sum_x = HALF - S2_W'(prod_reg[0]) + S2_W'(prod_reg[1])
                 - S2_W'(prod_reg[2]) + S2_W'(prod_reg[3]);
    assign sum_y = HALF - S2_W'(prod_reg[4]) + S2_W'(prod_reg[5])
                 - S2_W'(prod_reg[6]) + S2_W'(prod_reg[7]);
    assign sum_z = HALF - S2_W'(prod_reg[8]) + S2_W'(prod_reg[9])
                 - S2_W'(prod_reg[10]) + S2_W'(prod_reg[11]);

    assign cx = clip(sum_x[S2_W-1:QUAT_FRAC]);
    assign cy = clip(sum_y[S2_W-1:QUAT_FRAC]);
    assign cz = clip(sum_z[S2_W-1:QUAT_FRAC]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en_prod)
            begin
                prod_valid_reg <= in_valid;
            end
            if (en_res)
            begin
                res_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_prod && in_valid)
        begin
            prod_reg      <= prod_next;
            prod_last_reg <= in_last;
        end
        if (en_res && prod_valid_reg)
        begin
            rx_reg       <= cx[COORD_WIDTH-1:0];
            ry_reg       <= cy[COORD_WIDTH-1:0];
            rz_reg       <= cz[COORD_WIDTH-1:0];
            sat_reg      <= cx[COORD_WIDTH] | cy[COORD_WIDTH] | cz[COORD_WIDTH];
            res_last_reg <= prod_last_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign rot_x     = rx_reg;
    assign rot_y     = ry_reg;
    assign rot_z     = rz_reg;
    assign saturated = sat_reg;
    assign out_last  = res_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && sat_reg) |->
            (rx_reg == COORD_MAX || rx_reg == COORD_MIN || ry_reg == COORD_MAX ||
             ry_reg == COORD_MIN || rz_reg == COORD_MAX || rz_reg == COORD_MIN))
        else $error("saturation flagged but no coordinate at a range limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (prod_valid_reg && res_valid_reg && !out_ready))
        else $error("right multiplier stalled without a full pipeline");

endmodule

FILE: rtl/core/quaternion_point_rotator.sv
// Top level of the quaternion point rotator: configuration registers and the pipeline.
//
// Usage: software writes the origin (indexes 0..2, signed Q15.16) and the unit
// quaternion w, x, y, z (indexes 3..6, signed Q1.16) through cfg_we, cfg_addr and
// cfg_wdata while no point is in flight. Points arrive as stream transfers on the
// s_ side; each point produces exactly one result transfer on the m_ side holding
// the rotated offset (point minus origin), a saturation flag in m_tuser and the
// input tlast copied to m_tlast.
// Pipeline stages: origin subtract, two product stages, two rounding stages.
// Throughput: one point per cycle while m_tready is high; each of the five stages holds
// one item and carries its own valid bit.
// Reset empties the pipeline and loads the identity rotation about the origin zero.
// When the receiver holds m_tready low, bubbles in the pipeline still close up and
// s_tready falls only once every stage holds a point; nothing is dropped or repeated.
module quaternion_point_rotator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [qpr_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [qpr_pkg::COORD_WIDTH-1:0]        cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [qpr_pkg::TDATA_W-1:0]            s_tdata,  // pos_x, pos_y, pos_z
    input  logic                                   s_tlast,  // last_in
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [qpr_pkg::TDATA_W-1:0]            m_tdata,  // rot_x, rot_y, rot_z
    output logic                                   m_tuser,  // saturated
    output logic                                   m_tlast   // last_out
);
    import qpr_pkg::*;

    logic signed [COORD_WIDTH-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    quat_t                         quat_reg;

    logic                   off_valid, off_ready, off_last;
    logic signed [D_W-1:0]  dx, dy, dz;
    logic                   t_valid, t_ready, t_last;
    logic signed [T_W-1:0]  ts, ti, tj, tk;
    logic signed [COORD_WIDTH-1:0] rot_x, rot_y, rot_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            quat_reg.w   <= QUAT_ONE;
            quat_reg.x   <= '0;
            quat_reg.y   <= '0;
            quat_reg.z   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                REG_ORIGIN_Z: origin_z_reg <= cfg_wdata;
                REG_QUAT_W:   quat_reg.w   <= cfg_wdata[QUAT_WIDTH-1:0];
                REG_QUAT_X:   quat_reg.x   <= cfg_wdata[QUAT_WIDTH-1:0];
                REG_QUAT_Y:   quat_reg.y   <= cfg_wdata[QUAT_WIDTH-1:0];
                REG_QUAT_Z:   quat_reg.z   <= cfg_wdata[QUAT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    qpr_offset u_offset (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pos_x     (s_tdata[COORD_WIDTH-1:0]),
        .pos_y     (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .pos_z     (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .in_last   (s_tlast),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .origin_z  (origin_z_reg),
        .out_valid (off_valid),
        .out_ready (off_ready),
        .dx        (dx),
        .dy        (dy),
        .dz        (dz),
        .out_last  (off_last)
    );

    qpr_left_mul u_left_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (off_valid),
        .in_ready  (off_ready),
        .dx        (dx),
        .dy        (dy),
        .dz        (dz),
        .in_last   (off_last),
        .quat      (quat_reg),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .ts        (ts),
        .ti        (ti),
        .tj        (tj),
        .tk        (tk),
        .out_last  (t_last)
    );

    qpr_right_mul u_right_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .ts        (ts),
        .ti        (ti),
        .tj        (tj),
        .tk        (tk),
        .in_last   (t_last),
        .quat      (quat_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .saturated (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = TDATA_W'({rot_z, rot_y, rot_x});

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output side was free");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result presented right after reset");

endmodule
